// ----- rtl/dq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared types for the double-ended queue
// Command codes, word width and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_QUERY      = 3'd4
  } dq_cmd_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch incoming word
    logic rd_pop;   // read the slot a pop would take
    logic commit;   // update pointers, write the pushed word
    logic fetch;    // read the new front and back slots
    logic load;     // move the result into the output register
  } dq_ctl_t;

endpackage

// ----- rtl/dq_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ifs: valid/ready channels of the double-ended queue
// Command channel into the queue and result channel out of it.
// ----------------------------------------------------------------------------
interface dq_in_if import dq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface dq_out_if import dq_pkg::*; #(
  parameter int CntW = 11
) ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic                     pop_failed;
  logic                     push_refused;
  logic [CntW-1:0]          item_count;
  logic                     is_empty;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;

  modport source (output valid, popped_value, pop_failed, push_refused, item_count,
                  is_empty, front_value, back_value, input ready);
  modport sink   (input valid, popped_value, pop_failed, push_refused, item_count,
                  is_empty, front_value, back_value, output ready);
endinterface

// ----- rtl/double_ended_queue.sv -----
`timescale 1ns / 1ps
// A result word is loaded after its command word has passed the read, update
// and fetch steps; no new command is accepted before the result is loaded. The
//   memory is read in two steps and written at most once per command, in separate steps.
// A full output register stalls the sequence in its last step only.
// Reset (rst_ni low, asynchronous): deque empty, head at slot 0, no result held.
//   Memory contents are not cleared; only written slots are ever reported.
// ----------------------------------------------------------------------------
// double_ended_queue: deque of signed 32-bit words in a ring buffer
// Push/pop at either end or query; every command returns one result word with
// the popped word, failure flags, count and the current front and back words.
// ----------------------------------------------------------------------------
module double_ended_queue import dq_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input logic       clk_i,
  input logic       rst_ni,
  dq_in_if.sink     in_i,   // command words
  dq_out_if.source  out_o   // result words; CntW must equal $clog2(DEPTH + 1)
);

  localparam int CntW = $clog2(DEPTH + 1);

  dq_ctl_t ctl;

  logic signed [DATA_W-1:0] popped_value, front_value, back_value;
  logic                     pop_failed, push_refused, is_empty;
  logic [CntW-1:0]          item_count;

  // Controller: walks each command through
  //   READ   - registered read of the slot a pop would remove
  //   UPDATE - head/count update, pushed word written
  //   FETCH  - registered reads of the new front and back slots
  //   LOAD   - result into the output register (waits if it is still full)
  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctl_o       (ctl)
  );

  // Datapath: word memory, head index, held count, output register
  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .cmd_i          (in_i.cmd),
    .value_i        (in_i.value),
    .popped_value_o (popped_value),
    .pop_failed_o   (pop_failed),
    .push_refused_o (push_refused),
    .item_count_o   (item_count),
    .is_empty_o     (is_empty),
    .front_value_o  (front_value),
    .back_value_o   (back_value)
  );

  assign out_o.popped_value = popped_value;
  assign out_o.pop_failed   = pop_failed;
  assign out_o.push_refused = push_refused;
  assign out_o.item_count   = item_count;
  assign out_o.is_empty     = is_empty;
  assign out_o.front_value  = front_value;
  assign out_o.back_value   = back_value;

endmodule

// ----- rtl/dq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_datapath: ring buffer storage and pointers
// Word memory (one write, two registered reads), head and count registers,
// result and output registers.
// ----------------------------------------------------------------------------
module dq_datapath import dq_pkg::*; #(
  parameter  int DEPTH = 1024,
  localparam int IdxW  = $clog2(DEPTH),
  localparam int CntW  = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dq_ctl_t                  ctl_i,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic signed [DATA_W-1:0] popped_value_o,
  output logic                     pop_failed_o,
  output logic                     push_refused_o,
  output logic [CntW-1:0]          item_count_o,
  output logic                     is_empty_o,
  output logic signed [DATA_W-1:0] front_value_o,
  output logic signed [DATA_W-1:0] back_value_o
);

  localparam int SumW = IdxW + 1;

  function automatic logic [IdxW-1:0] wrap_idx(input logic [SumW-1:0] s);
    if (s >= SumW'(DEPTH)) begin
      return IdxW'(s - SumW'(DEPTH));
    end
    return IdxW'(s);
  endfunction

  logic [DATA_W-1:0] word_mem [DEPTH];

  logic [IdxW-1:0]          head_q, head_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  dq_cmd_e                  cmd_q;
  logic signed [DATA_W-1:0] value_q;
  logic [DATA_W-1:0]        rdata_a_q, rdata_b_q;

  logic [DATA_W-1:0] popped_q, popped_d;
  logic              fail_q, fail_d;
  logic              refused_q, refused_d;

  logic [IdxW-1:0] back_idx, tail_idx, head_dec, head_inc, addr_a, wr_addr;
  logic            empty, full, wr_en, rd_en_a;

  assign empty    = (cnt_q == '0);
  assign full     = (cnt_q == CntW'(DEPTH));
  // back slot is only meaningful with words held; empty falls back to head
  assign back_idx = empty ? head_q : wrap_idx(SumW'(head_q) + SumW'(cnt_q) - SumW'(1));
  assign tail_idx = wrap_idx(SumW'(head_q) + SumW'(cnt_q));
  assign head_dec = (head_q == '0) ? IdxW'(DEPTH - 1) : head_q - IdxW'(1);
  assign head_inc = wrap_idx(SumW'(head_q) + SumW'(1));

  // port A: pop slot during rd_pop, new front during fetch
  assign rd_en_a = ctl_i.rd_pop | ctl_i.fetch;
  assign addr_a  = (ctl_i.rd_pop && cmd_q == CMD_POP_BACK) ? back_idx : head_q;

  always_comb begin
    head_d    = head_q;
    cnt_d     = cnt_q;
    wr_en     = 1'b0;
    wr_addr   = tail_idx;
    popped_d  = '0;
    fail_d    = 1'b0;
    refused_d = 1'b0;
    if (ctl_i.commit) begin
      unique case (cmd_q)
        CMD_PUSH_FRONT: begin
          if (full) begin
            refused_d = 1'b1;
          end else begin
            head_d  = head_dec;
            wr_addr = head_dec;
            wr_en   = 1'b1;
            cnt_d   = cnt_q + CntW'(1);
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            refused_d = 1'b1;
          end else begin
            wr_en = 1'b1;
            cnt_d = cnt_q + CntW'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            fail_d = 1'b1;
          end else begin
            popped_d = rdata_a_q;
            head_d   = head_inc;
            cnt_d    = cnt_q - CntW'(1);
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            fail_d = 1'b1;
          end else begin
            popped_d = rdata_a_q;
            cnt_d    = cnt_q - CntW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      word_mem[wr_addr] <= value_q;
    end
    if (rd_en_a) begin
      rdata_a_q <= word_mem[addr_a];
    end
    if (ctl_i.fetch) begin
      rdata_b_q <= word_mem[back_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q   <= dq_cmd_e'(cmd_i);
      value_q <= value_i;
    end
    if (ctl_i.commit) begin
      popped_q  <= popped_d;
      fail_q    <= fail_d;
      refused_q <= refused_d;
    end
    if (ctl_i.load) begin
      popped_value_o <= popped_q;
      pop_failed_o   <= fail_q;
      push_refused_o <= refused_q;
      item_count_o   <= cnt_q;
      is_empty_o     <= empty;
      front_value_o  <= empty ? '0 : rdata_a_q;
      back_value_o   <= empty ? '0 : rdata_b_q;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("held count above depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.commit |=> (cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + 1'b1 ||
                      cnt_q == $past(cnt_q) - 1'b1))
    else $error("count moved by more than one word");

  a_ptr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.commit |=> ($stable(cnt_q) && $stable(head_q)))
    else $error("pointers changed outside commit");
`endif

endmodule

// ----- rtl/dq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl: sequencing of one command through the datapath
// Accept, pop read, commit, fetch of front/back, load of the output register.
// ----------------------------------------------------------------------------
module dq_ctrl import dq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dq_ctl_t ctl_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_FETCH,
    ST_LOAD
  } state_e;

  state_e state_q;
  logic   in_ready_q, out_valid_q, rd_pop_q, commit_q, fetch_q;
  logic   load;

  // output register free, or its word leaves this cycle
  assign load = (state_q == ST_LOAD) && (!out_valid_q || out_ready_i);

  assign in_ready_o    = in_ready_q;
  assign out_valid_o   = out_valid_q;
  assign ctl_o.capture = in_valid_i & in_ready_q;
  assign ctl_o.rd_pop  = rd_pop_q;
  assign ctl_o.commit  = commit_q;
  assign ctl_o.fetch   = fetch_q;
  assign ctl_o.load    = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rd_pop_q    <= 1'b0;
      commit_q    <= 1'b0;
      fetch_q     <= 1'b0;
    end else begin
      // a load in the same cycle refills the output register instead
      if (out_valid_q && out_ready_i && !load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            in_ready_q <= 1'b0;
            rd_pop_q   <= 1'b1;
            state_q    <= ST_READ;
          end else begin
            in_ready_q <= 1'b1;
          end
        end
        ST_READ: begin
          rd_pop_q <= 1'b0;
          commit_q <= 1'b1;
          state_q  <= ST_UPDATE;
        end
        ST_UPDATE: begin
          commit_q <= 1'b0;
          fetch_q  <= 1'b1;
          state_q  <= ST_FETCH;
        end
        ST_FETCH: begin
          fetch_q <= 1'b0;
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          if (load) begin
            out_valid_q <= 1'b1;
            in_ready_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.capture |=> (ctl_o.rd_pop && !in_ready_o))
    else $error("accepted word not followed by pop read");

  a_commit_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.commit |=> (ctl_o.fetch && !ctl_o.commit))
    else $error("commit not followed by fetch");
`endif

endmodule

// ----- tb/sv/tb_double_ended_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue: self-checking bench for the ring-buffer deque
// Drives command words over valid/ready, predicts the resulting view of the
// deque in a local ring buffer and compares every result word field by field.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
  import dq_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int DRAIN_CYCLES = 20;
  localparam longint TIMEOUT_NS = 2_000_000;  // far above a clean run

  // codes the block does not define; it must treat them as a query
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_W'(CMD_QUERY + 1);
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = '1;

  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  // one result word, as the block should report it
  typedef struct packed {
    logic signed [DATA_W-1:0] popped;
    logic                     pop_failed;
    logic                     push_refused;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] back;
  } deque_view_t;

  logic clk_i;
  logic rst_ni;

  dq_in_if                   in_if ();
  dq_out_if #(.CntW(CNT_W))  out_if ();

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // --------------------------------------------------------------------------
  // Predicted deque: its own ring, head slot and word count
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] ring_words [DEPTH];
  logic [IDX_W-1:0]         front_slot;
  logic [CNT_W-1:0]         word_count;

  deque_view_t pending_views [$];   // views still owed by the block, oldest first
  int          mismatches;

  // idle percentages; the receiver's long hold-off is requested by a test
  int send_idle_pct;
  int recv_idle_pct;
  int stall_request;

  // Apply one command to the predicted deque and return the view after it.
  function automatic deque_view_t apply_deque_cmd(input logic [CMD_W-1:0] cmd,
                                                  input logic signed [DATA_W-1:0] word);
    deque_view_t view;
    view = '0;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (word_count == DEPTH) begin
          view.push_refused = 1'b1;           // full: word dropped, nothing moves
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            front_slot = (front_slot == 0) ? IDX_W'(DEPTH - 1) : front_slot - 1'b1;
            ring_words[front_slot] = word;
          end else begin
            ring_words[IDX_W'((front_slot + word_count) % DEPTH)] = word;
          end
          word_count++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (word_count == 0) begin
          view.pop_failed = 1'b1;             // empty: popped stays zero
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            view.popped = ring_words[front_slot];
            front_slot  = IDX_W'((front_slot + 1) % DEPTH);
          end else begin
            view.popped = ring_words[IDX_W'((front_slot + word_count - 1) % DEPTH)];
          end
          word_count--;
        end
      end
      default: ;                              // query and spare codes
    endcase
    view.count    = word_count;
    view.is_empty = (word_count == 0);
    if (word_count != 0) begin
      view.front = ring_words[front_slot];
      view.back  = ring_words[IDX_W'((front_slot + word_count - 1) % DEPTH)];
    end
    return view;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset, timeout
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready, plus a long hold-off counted here when requested
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left   = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_request != 0) begin
        stall_left    = stall_request;
        stall_request = 0;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted result word against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic report_field(input string field, input longint want_v,
                              input longint got_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    deque_view_t want;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_views.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        mismatches++;
      end else begin
        want = pending_views[0];
        pending_views.delete(0);
        if (out_if.popped_value !== want.popped)
          report_field("popped_value", want.popped, out_if.popped_value);
        if (out_if.pop_failed !== want.pop_failed)
          report_field("pop_failed", want.pop_failed, out_if.pop_failed);
        if (out_if.push_refused !== want.push_refused)
          report_field("push_refused", want.push_refused, out_if.push_refused);
        if (out_if.item_count !== want.count)
          report_field("item_count", want.count, out_if.item_count);
        if (out_if.is_empty !== want.is_empty)
          report_field("is_empty", want.is_empty, out_if.is_empty);
        if (out_if.front_value !== want.front)
          report_field("front_value", want.front, out_if.front_value);
        if (out_if.back_value !== want.back)
          report_field("back_value", want.back, out_if.back_value);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one command word; predict its result once it is taken. Valid is
  // left high so back-to-back words need no second assignment in one step.
  task automatic issue_cmd(input logic [CMD_W-1:0] cmd,
                           input logic signed [DATA_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= cmd;
    in_if.value <= word;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    pending_views.insert(pending_views.size(), apply_deque_cmd(cmd, word));
  endtask

  // Sender pause: drop valid until every owed result word has come back.
  task automatic wait_for_views();
    in_if.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
  endtask

  // Word with the extremes, all ones and zero mixed in.
  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return -1;
      3:       return 0;
      default: return $urandom;
    endcase
  endfunction

  // Command mix: push_pct percent pushes, pops up to 90, then query/spare.
  function automatic logic [CMD_W-1:0] pick_cmd(input int push_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_pct)
      return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    else if (roll < 90)
      return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
    else if (roll < 95)
      return CMD_QUERY;
    else
      return CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every command on an empty deque, the word extremes, head wrap below slot 0.
  task automatic test_directed_ops();
    issue_cmd(CMD_POP_FRONT, WORD_MAX);        // pop from empty, front end
    issue_cmd(CMD_POP_BACK, WORD_MIN);         // pop from empty, back end
    issue_cmd(CMD_QUERY, -1);
    for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
      issue_cmd(CMD_W'(c), -1);                // unknown codes act as query
    issue_cmd(CMD_PUSH_FRONT, WORD_MIN);       // head wraps to the top slot
    issue_cmd(CMD_PUSH_BACK, WORD_MAX);
    issue_cmd(CMD_PUSH_FRONT, -1);
    issue_cmd(CMD_PUSH_BACK, 0);
    issue_cmd(CMD_QUERY, WORD_MAX);
    issue_cmd(CMD_POP_BACK, 0);
    issue_cmd(CMD_POP_FRONT, 0);
    issue_cmd(CMD_POP_BACK, 0);
    issue_cmd(CMD_POP_FRONT, 0);               // back to empty
    issue_cmd(CMD_POP_FRONT, 0);
    issue_cmd(CMD_PUSH_BACK, 32'sh5555_5555);
    issue_cmd(CMD_PUSH_FRONT, 32'shaaaa_aaaa);
    issue_cmd(CMD_SPARE_LAST, 32'sh1234_5678); // value ignored
    issue_cmd(CMD_POP_FRONT, 0);
    issue_cmd(CMD_POP_BACK, 0);
    wait_for_views();
  endtask

  // Grow from both ends across the top/bottom seam of the ring, then drain.
  task automatic test_wrap_around();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 24; i++)
      issue_cmd(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_word());
    issue_cmd(CMD_QUERY, 0);
    for (int i = 0; i < 24; i++)
      issue_cmd($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK, 0);
    issue_cmd(CMD_POP_BACK, 0);                // empty again
    wait_for_views();
  endtask

  // Receiver holds off for a long stretch while words keep coming.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 300;
    repeat (40) issue_cmd(pick_cmd(60), pick_word());
    wait_for_views();
  endtask

  // Random traffic in segments that lean toward filling, draining or neither.
  task automatic run_random_phase(input int send_pct, input int recv_pct,
                                  input int n_words);
    int push_pct;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    push_pct      = 45;
    for (int i = 0; i < n_words; i++) begin
      if (i % 16 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 70;
          1:       push_pct = 25;
          default: push_pct = 45;
        endcase
      end
      issue_cmd(pick_cmd(push_pct), pick_word());
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(22, 57, 140);
    run_random_phase(57, 22, 140);
    run_random_phase(0, 0, 140);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    mismatches    = 0;
    stall_request = 0;
    send_idle_pct = 22;
    recv_idle_pct = 57;
    front_slot    = '0;
    word_count    = '0;
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.cmd    <= CMD_QUERY;
    in_if.value  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ops();
    test_wrap_around();
    test_backpressure();
    test_random_traffic();

    wait_for_views();
    repeat (DRAIN_CYCLES) @(posedge clk_i);   // catch any stray result word
    if (mismatches == 0 && pending_views.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
